@@ hdl/alcu_pkg.sv @@
// Shared types, constants and the aging rule for the aging Life cell block.
package alcu_pkg;

    // Fixed field widths
    localparam int AGE_W = 4;
    localparam int COL_W = 6;
    localparam int ROW_W = 6;
    localparam int CFG_W = 7;
    localparam int CNT_W = 4;

    // Default grid bounds
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // Size registers
    localparam int                MIN_SIZE   = 3;
    localparam logic [CFG_W-1:0]  SIZE_RESET = 7'd64;
    localparam logic              REG_WIDTH  = 1'b0;
    localparam logic              REG_HEIGHT = 1'b1;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Aging rule constants
    localparam logic [AGE_W-1:0] AGE_DEAD   = 4'd0;
    localparam logic [AGE_W-1:0] AGE_MAX    = 4'd9;
    localparam logic [AGE_W-1:0] AGE_BORN   = 4'd1;
    localparam logic [CNT_W-1:0] SURVIVE_LO = 4'd2;
    localparam logic [CNT_W-1:0] BIRTH_CNT  = 4'd3;

    // Read sequence: the cell itself, then its eight neighbors
    localparam logic [CNT_W-1:0] SELF_READ = 4'd0;
    localparam logic [CNT_W-1:0] LAST_READ = 4'd8;
    localparam logic [CNT_W-1:0] NUM_READS = 4'd9;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_FINISH
    } alcu_state_t;

    typedef struct packed {
        logic [AGE_W-1:0] next_age;
        logic [CNT_W-1:0] live_neighbors;
        logic             bad_coordinate;
    } alcu_result_t;

    // Next generation age from current age and live neighbor count
    function automatic logic [AGE_W-1:0] next_age_f(input logic [AGE_W-1:0] self,
                                                     input logic [CNT_W-1:0] cnt);
        logic [AGE_W-1:0] res;
        res = AGE_DEAD;
        if (self != AGE_DEAD) begin
            if (cnt == SURVIVE_LO || cnt == BIRTH_CNT) begin
                res = (self >= AGE_MAX) ? AGE_MAX : self + AGE_BORN;
            end
        end else if (cnt == BIRTH_CNT) begin
            res = AGE_BORN;
        end
        return res;
    endfunction

endpackage

@@ hdl/alcu_grid_mem.sv @@
// Single-port synchronous cell grid memory with a registered read.
module alcu_grid_mem
    import alcu_pkg::*;
#(
    parameter  int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [AGE_W-1:0] wdata,
    output logic [AGE_W-1:0] rdata
);

    logic [AGE_W-1:0] mem [DEPTH];
    logic [AGE_W-1:0] rdata_reg;

    // Read-first single port
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/alcu_ctrl.sv @@
// Sequencer: grid clear, cell writes, nine-read neighbor evaluation, result register.
module alcu_ctrl
    import alcu_pkg::*;
#(
    parameter  int MAX_COLS = DEF_MAX_COLS,
    parameter  int MAX_ROWS = DEF_MAX_ROWS,
    localparam int CSW      = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W,
    localparam int RSW      = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W,
    localparam int DEPTH    = MAX_COLS * MAX_ROWS,
    localparam int AW       = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CSW-1:0]   w_eff,
    input  logic [RSW-1:0]   h_eff,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             op,
    input  logic [COL_W-1:0] col,
    input  logic [ROW_W-1:0] row,
    input  logic [AGE_W-1:0] cell_age,
    output logic             out_valid,
    input  logic             out_ready,
    output alcu_result_t     result,
    output logic             mem_en,
    output logic             mem_we,
    output logic [AW-1:0]    mem_addr,
    output logic [AGE_W-1:0] mem_wdata,
    input  logic [AGE_W-1:0] mem_rdata
);

    alcu_state_t      state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic             bad_reg, bad_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0] rd_tag_reg, rd_tag_next;
    logic [AGE_W-1:0] self_reg, self_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    alcu_result_t     res_reg, res_next;

    logic [CSW-1:0]   cc, cl, cr, sel_c;
    logic [RSW-1:0]   rc, ru, rd, sel_r;
    logic             in_bad;
    logic             accept;

    // Wrapped neighbor coordinates
    always_comb
    begin
        cc = CSW'(col_reg);
        rc = RSW'(row_reg);
        cl = (col_reg == '0) ? w_eff - CSW'(1) : cc - CSW'(1);
        cr = (cc + CSW'(1) == w_eff) ? '0 : cc + CSW'(1);
        ru = (row_reg == '0) ? h_eff - RSW'(1) : rc - RSW'(1);
        rd = (rc + RSW'(1) == h_eff) ? '0 : rc + RSW'(1);
    end

    // Coordinate for the current read slot
    always_comb
    begin
        case (rd_cnt_reg)
            4'd0:    begin sel_c = cc; sel_r = rc; end
            4'd1:    begin sel_c = cl; sel_r = ru; end
            4'd2:    begin sel_c = cc; sel_r = ru; end
            4'd3:    begin sel_c = cr; sel_r = ru; end
            4'd4:    begin sel_c = cl; sel_r = rc; end
            4'd5:    begin sel_c = cr; sel_r = rc; end
            4'd6:    begin sel_c = cl; sel_r = rd; end
            4'd7:    begin sel_c = cc; sel_r = rd; end
            4'd8:    begin sel_c = cr; sel_r = rd; end
            default: begin sel_c = cc; sel_r = rc; end
        endcase
    end

    assign in_bad   = (CSW'(col) >= w_eff) || (RSW'(row) >= h_eff);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        age_reg    <= age_next;
        bad_reg    <= bad_next;
        rd_tag_reg <= rd_tag_next;
        self_reg   <= self_next;
        count_reg  <= count_next;
        res_reg    <= res_next;
    end

    // Next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        age_next       = age_reg;
        bad_next       = bad_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = 1'b0;
        rd_tag_next    = rd_tag_reg;
        self_next      = self_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = AW'(sel_r * MAX_COLS + sel_c);
        mem_wdata      = age_reg;

        // Returning read data
        if (rd_pend_reg)
        begin
            if (rd_tag_reg == SELF_READ)
            begin
                self_next = mem_rdata;
            end
            else if (mem_rdata != AGE_DEAD)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = AGE_DEAD;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next    = col;
                    row_next    = row;
                    age_next    = (cell_age > AGE_MAX) ? AGE_MAX : cell_age;
                    bad_next    = in_bad;
                    rd_cnt_next = '0;
                    count_next  = '0;
                    if (op == OP_WRITE)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (in_bad)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_addr   = AW'(RSW'(row_reg) * MAX_COLS + CSW'(col_reg));
                mem_en     = !bad_reg;
                mem_we     = !bad_reg;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (rd_cnt_reg != NUM_READS)
                begin
                    mem_en       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_tag_next  = rd_cnt_reg;
                    rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                end
                if (rd_pend_reg && rd_tag_reg == LAST_READ)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next.bad_coordinate = bad_reg;
                    res_next.live_neighbors = bad_reg ? '0 : count_reg;
                    res_next.next_age       = bad_reg ? AGE_DEAD
                                                      : next_age_f(self_reg, count_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

@@ hdl/aging_life_cell_update.sv @@
// Top level of the aging Life cell block: size registers, clamping, grid and sequencer.
//
// Holds a toroidal grid of MAX_COLS x MAX_ROWS aging Life cells (ages 0..9, 0 dead) in a
// single-port memory. After reset the block sweeps the grid to zero, one cell per cycle,
// and accepts no item meanwhile; size register writes are taken at any time. A write item
// is the transfer plus one memory write. An evaluate item makes nine reads of the one-port
// grid memory (the cell and its eight wrapped neighbors), waits for the registered data of
// the last read and then loads the result register. An evaluate of a bad coordinate skips
// the reads and goes straight to loading the result register. The result register lets
// the next item transfer in while a result waits to be taken.
module aging_life_cell_update
    import alcu_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             op,
    input  logic [COL_W-1:0] col,
    input  logic [ROW_W-1:0] row,
    input  logic [AGE_W-1:0] cell_age,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [AGE_W-1:0] next_age,
    output logic [CNT_W-1:0] live_neighbors,
    output logic             bad_coordinate
);

    localparam int CSW   = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
    localparam int RSW   = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CSW-1:0]   w_ext, w_eff;
    logic [RSW-1:0]   h_ext, h_eff;
    alcu_result_t     result;
    logic             mem_en, mem_we;
    logic [AW-1:0]    mem_addr;
    logic [AGE_W-1:0] mem_wdata, mem_rdata;

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Clamp sizes to 3..MAX
    always_comb
    begin
        w_ext = CSW'(width_reg);
        h_ext = RSW'(height_reg);
        if (w_ext < CSW'(MIN_SIZE))
            w_eff = CSW'(MIN_SIZE);
        else if (w_ext > CSW'(MAX_COLS))
            w_eff = CSW'(MAX_COLS);
        else
            w_eff = w_ext;
        if (h_ext < RSW'(MIN_SIZE))
            h_eff = RSW'(MIN_SIZE);
        else if (h_ext > RSW'(MAX_ROWS))
            h_eff = RSW'(MAX_ROWS);
        else
            h_eff = h_ext;
    end

    alcu_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .col       (col),
        .row       (row),
        .cell_age  (cell_age),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    alcu_grid_mem #(
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign next_age       = result.next_age;
    assign live_neighbors = result.live_neighbors;
    assign bad_coordinate = result.bad_coordinate;

endmodule

@@ test/aging_life_cell_update_test.sv @@
// Testbench for the aging Life cell block: directed and random items checked against a grid model.
module aging_life_cell_update_test;
    import alcu_pkg::*;

    localparam int               GRID_COLS     = DEF_MAX_COLS;
    localparam int               GRID_ROWS     = DEF_MAX_ROWS;
    localparam logic [COL_W-1:0] COORD_TOP     = '1;
    localparam logic [CFG_W-1:0] SIZE_TOP      = '1;
    localparam logic [AGE_W-1:0] AGE_TOP       = '1;
    localparam int               GAP_MAX       = 14;
    localparam int               SETTLE_CYCLES = 16;
    localparam int               RANDOM_PHASES = 13;
    localparam int               PHASE_ITEMS   = 105;
    localparam int               HOLD_CYCLES   = 400;
    localparam int               RUN_LIMIT     = 4000000;

    // Block ports, all inputs known from time zero
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = REG_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic             op        = OP_WRITE;
    logic [COL_W-1:0] col       = '0;
    logic [ROW_W-1:0] row       = '0;
    logic [AGE_W-1:0] cell_age  = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [AGE_W-1:0] next_age;
    logic [CNT_W-1:0] live_neighbors;
    logic             bad_coordinate;

    // Grid model, size registers and outstanding evaluate results
    logic [AGE_W-1:0] life_grid [GRID_COLS*GRID_ROWS];
    logic [CFG_W-1:0] width_setting  = SIZE_RESET;
    logic [CFG_W-1:0] height_setting = SIZE_RESET;
    alcu_result_t     pending_results [$];

    // Traffic shaping
    int unsigned feed_gap_max = 0;
    int unsigned sink_gap_max = 0;
    logic        sink_hold    = 1'b0;

    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned size_settings   = 0;

    aging_life_cell_update dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .col            (col),
        .row            (row),
        .cell_age       (cell_age),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_age       (next_age),
        .live_neighbors (live_neighbors),
        .bad_coordinate (bad_coordinate)
    );

    // 10 unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Size in use: register clamped to MIN_SIZE..limit
    function automatic int unsigned used_size(input logic [CFG_W-1:0] setting,
                                              input int unsigned limit);
        if (setting < MIN_SIZE)
            return MIN_SIZE;
        if (setting > limit)
            return limit;
        return 32'(setting);
    endfunction

    // Apply one accepted item to the grid model; evaluates queue their result
    function automatic void predict_transfer(input logic op_i, input logic [COL_W-1:0] c,
                                             input logic [ROW_W-1:0] r,
                                             input logic [AGE_W-1:0] a);
        int unsigned      w;
        int unsigned      h;
        int unsigned      cols [3];
        int unsigned      rows [3];
        int               i;
        int               j;
        logic [CNT_W-1:0] live;
        logic [AGE_W-1:0] self_age;
        alcu_result_t     res;
        w = used_size(width_setting, GRID_COLS);
        h = used_size(height_setting, GRID_ROWS);
        res.next_age       = AGE_DEAD;
        res.live_neighbors = '0;
        res.bad_coordinate = 1'b0;
        if (c >= w || r >= h)
        begin
            // off the grid in use: writes dropped, evaluates flagged
            if (op_i == OP_EVAL)
            begin
                res.bad_coordinate = 1'b1;
                pending_results.push_back(res);
            end
        end
        else if (op_i == OP_WRITE)
        begin
            life_grid[r * GRID_COLS + c] = (a > AGE_MAX) ? AGE_MAX : a;
        end
        else
        begin
            // wrapped neighborhood, plain modulo at the size in use
            cols[0] = (c + w - 1) % w;
            cols[1] = 32'(c);
            cols[2] = (c + 1) % w;
            rows[0] = (r + h - 1) % h;
            rows[1] = 32'(r);
            rows[2] = (r + 1) % h;
            live = '0;
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                    if (!(i == 1 && j == 1) &&
                        life_grid[rows[i] * GRID_COLS + cols[j]] != AGE_DEAD)
                        live = live + 1'b1;
            self_age = life_grid[r * GRID_COLS + c];
            if (self_age != AGE_DEAD)
            begin
                if (live == SURVIVE_LO || live == BIRTH_CNT)
                    res.next_age = (self_age >= AGE_MAX) ? AGE_MAX : self_age + 1'b1;
            end
            else if (live == BIRTH_CNT)
            begin
                res.next_age = AGE_BORN;
            end
            res.live_neighbors = live;
            pending_results.push_back(res);
        end
    endfunction

    // Random size register value, mostly small grids, some out of range
    function automatic logic [CFG_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return CFG_W'($urandom_range(8, MIN_SIZE));
        if (roll < 70)
            return CFG_W'($urandom_range(GRID_COLS, 9));
        if (roll < 80)
            return SIZE_RESET;
        if (roll < 90)
            return CFG_W'($urandom_range(MIN_SIZE - 1, 0));
        return CFG_W'($urandom_range(SIZE_TOP, GRID_COLS + 1));
    endfunction

    // Coordinate mostly inside the size in use, sometimes anywhere
    function automatic logic [COL_W-1:0] pick_coord(input int unsigned used);
        if ($urandom_range(99, 0) < 12)
            return COL_W'($urandom_range(COORD_TOP, 0));
        return COL_W'($urandom_range(used - 1, 0));
    endfunction

    // Age with a bias toward dead cells
    function automatic logic [AGE_W-1:0] pick_age();
        if ($urandom_range(99, 0) < 35)
            return AGE_DEAD;
        return AGE_W'($urandom_range(AGE_TOP, 0));
    endfunction

    // Offer one item after a random gap and wait for its transfer
    task automatic send_item(input logic op_i, input logic [COL_W-1:0] c,
                             input logic [ROW_W-1:0] r, input logic [AGE_W-1:0] a);
        int unsigned gap;
        gap = $urandom_range(feed_gap_max, 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_i;
        col      <= c;
        row      <= r;
        cell_age <= a;
        do
            @(posedge clk);
        while (!in_ready);
        predict_transfer(op_i, c, r, a);
        items_sent++;
    endtask

    // Stop offering, wait for every result, then let in-flight writes finish
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both size registers on back-to-back edges
    task automatic set_world_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_setting  = w;
        height_setting = h;
        size_settings++;
    endtask

    // Hold the receiver off for a fixed number of cycles
    task automatic stall_receiver(input int unsigned cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold <= 1'b0;
    endtask

    // Fresh grid after the clearing sweep reads dead at two opposite corners
    task automatic test_clear_grid();
        feed_gap_max = 0;
        sink_gap_max = 0;
        send_item(OP_EVAL, 6'd0, 6'd0, AGE_MAX);
        send_item(OP_EVAL, COORD_TOP, COORD_TOP, AGE_TOP);
    endtask

    // Corner wrap at full size, birth, aging and write saturation
    task automatic test_wrap_and_aging();
        drain_results();
        set_world_size(SIZE_RESET, SIZE_RESET);
        feed_gap_max = GAP_MAX;
        sink_gap_max = GAP_MAX;
        send_item(OP_WRITE, COORD_TOP, COORD_TOP, AGE_TOP);
        send_item(OP_WRITE, 6'd0, COORD_TOP, AGE_BORN);
        send_item(OP_WRITE, 6'd1, 6'd0, 4'd5);
        send_item(OP_EVAL, 6'd0, 6'd0, AGE_DEAD);
        send_item(OP_EVAL, 6'd0, COORD_TOP, AGE_DEAD);
        send_item(OP_EVAL, COORD_TOP, COORD_TOP, AGE_DEAD);
    endtask

    // Clamped sizes, writes and evaluates off the grid in use
    task automatic test_bad_coordinates();
        drain_results();
        set_world_size('0, SIZE_TOP);
        feed_gap_max = 0;
        sink_gap_max = GAP_MAX;
        send_item(OP_WRITE, COORD_TOP, COORD_TOP, 4'd7);
        send_item(OP_EVAL, COORD_TOP, COORD_TOP, AGE_DEAD);
        send_item(OP_EVAL, 6'd3, 6'd0, AGE_DEAD);
        send_item(OP_EVAL, 6'd2, COORD_TOP, AGE_DEAD);
        send_item(OP_EVAL, 6'd0, 6'd0, AGE_DEAD);
        drain_results();
        set_world_size(SIZE_TOP, 7'd2);
        send_item(OP_EVAL, 6'd0, 6'd3, AGE_DEAD);
        // cell kept from full size but out of reach now
        send_item(OP_EVAL, COORD_TOP, COORD_TOP, AGE_DEAD);
        send_item(OP_EVAL, COORD_TOP, 6'd2, AGE_DEAD);
    endtask

    // Smallest grid: old cell saturating, surviving, then overcrowded
    task automatic test_saturate_and_crowd();
        drain_results();
        set_world_size(CFG_W'(MIN_SIZE), CFG_W'(MIN_SIZE));
        feed_gap_max = GAP_MAX;
        sink_gap_max = 0;
        send_item(OP_WRITE, 6'd1, 6'd0, AGE_DEAD);
        send_item(OP_WRITE, 6'd1, 6'd1, AGE_MAX);
        send_item(OP_WRITE, 6'd0, 6'd0, 4'd3);
        send_item(OP_WRITE, 6'd2, 6'd2, 4'd4);
        send_item(OP_EVAL, 6'd1, 6'd1, AGE_DEAD);
        send_item(OP_WRITE, 6'd2, 6'd0, AGE_BORN);
        send_item(OP_EVAL, 6'd1, 6'd1, AGE_DEAD);
        send_item(OP_WRITE, 6'd0, 6'd2, 4'd2);
        send_item(OP_EVAL, 6'd1, 6'd1, AGE_DEAD);
    endtask

    // Receiver stalled long enough to back up the input, then a full pause
    task automatic test_backpressure();
        drain_results();
        set_world_size(7'd5, 7'd4);
        feed_gap_max = 0;
        sink_gap_max = 0;
        fork
            stall_receiver(HOLD_CYCLES);
        join_none
        repeat (30)
            send_item(($urandom_range(3, 0) != 0) ? OP_EVAL : OP_WRITE,
                      pick_coord(5), pick_coord(4), pick_age());
        // sender holds until the backlog has been taken
        drain_results();
        repeat (20)
            send_item(($urandom_range(1, 0) != 0) ? OP_EVAL : OP_WRITE,
                      pick_coord(5), pick_coord(4), pick_age());
    endtask

    // Random grids of varied sizes and idling
    task automatic test_random_grids();
        int          p;
        int unsigned w;
        int unsigned h;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            set_world_size(pick_size(), pick_size());
            feed_gap_max = ($urandom_range(1, 0) != 0) ? GAP_MAX : 0;
            sink_gap_max = ($urandom_range(1, 0) != 0) ? GAP_MAX : 0;
            w = used_size(width_setting, GRID_COLS);
            h = used_size(height_setting, GRID_ROWS);
            repeat (PHASE_ITEMS)
                send_item(($urandom_range(1, 0) != 0) ? OP_EVAL : OP_WRITE,
                          pick_coord(w), pick_coord(h), pick_age());
        end
    endtask

    // Result checker and receiver ready pattern
    initial
    begin : result_checker
        int unsigned  sink_wait;
        alcu_result_t want;
        sink_wait = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: next_age %0d live_neighbors %0d bad_coordinate %0d",
                           next_age, live_neighbors, bad_coordinate);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (next_age !== want.next_age)
                    begin
                        $error("next_age mismatch: expected %0d, actual %0d",
                               want.next_age, next_age);
                        error_count++;
                    end
                    if (live_neighbors !== want.live_neighbors)
                    begin
                        $error("live_neighbors mismatch: expected %0d, actual %0d",
                               want.live_neighbors, live_neighbors);
                        error_count++;
                    end
                    if (bad_coordinate !== want.bad_coordinate)
                    begin
                        $error("bad_coordinate mismatch: expected %0d, actual %0d",
                               want.bad_coordinate, bad_coordinate);
                        error_count++;
                    end
                    results_checked++;
                end
                sink_wait = $urandom_range(sink_gap_max, 0);
            end
            if (sink_hold)
                out_ready <= 1'b0;
            else if (sink_wait != 0)
            begin
                out_ready <= 1'b0;
                sink_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Test sequence
    initial
    begin : test_sequence
        foreach (life_grid[k])
            life_grid[k] = AGE_DEAD;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_clear_grid();
        test_wrap_and_aging();
        test_bad_coordinates();
        test_saturate_and_crowd();
        test_backpressure();
        test_random_grids();
        drain_results();
        if (pending_results.size() != 0)
        begin
            $error("%0d evaluate results never arrived", pending_results.size());
            error_count++;
        end
        $display("Covered %0d item transfers and %0d checked results over %0d size settings,",
                 items_sent, results_checked, size_settings);
        $display("including wrap, clamping, off-grid cells, aging rules and a long output stall.");
        if (error_count == 0)
            $display("[aging_life_cell_update] OK");
        else
            $display("[aging_life_cell_update] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("[aging_life_cell_update] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hdl/alcu_pkg.sv
hdl/alcu_grid_mem.sv
hdl/alcu_ctrl.sv
hdl/aging_life_cell_update.sv
test/aging_life_cell_update_test.sv
